// ----- sv/ffa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffa_pkg
// shared constants and types of the flat-field attenuation pipeline
// ----------------------------------------------------------------------------
package ffa_pkg;

	localparam int DEF_FRAC_BITS  = 16;
	localparam int DEF_PIXEL_BITS = 16;
	localparam int COUNT_WIDTH    = 16;
	localparam int ATT_WIDTH      = 21;
	localparam int STAT_WIDTH     = 3;
	localparam int LOG_FRAC       = 30;
	localparam int MANT_WIDTH     = 32;
	localparam int LN2_WIDTH      = 28;
	localparam logic [LN2_WIDTH-1:0] LN2_Q28 = 28'd186065280;
	localparam int LO_SPLIT       = 17;

	localparam logic [STAT_WIDTH-1:0] STAT_OK   = 3'd0;
	localparam logic [STAT_WIDTH-1:0] STAT_BOTH = 3'd1;
	localparam logic [STAT_WIDTH-1:0] STAT_HIGH = 3'd2;
	localparam logic [STAT_WIDTH-1:0] STAT_LOW  = 3'd3;
	localparam logic [STAT_WIDTH-1:0] STAT_NEG  = 3'd4;

	typedef struct packed {
		logic [STAT_WIDTH-1:0] status;
		logic                  ordinary;
	} ctl_t;

endpackage

// ----- sv/ffa_prep.sv -----
// ----------------------------------------------------------------------------
// ffa_prep
// differences, classification and mantissa normalization (two stages)
// ----------------------------------------------------------------------------
module ffa_prep #(
	parameter int PIXEL_BITS = 16,
	parameter int NW         = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  logic [PIXEL_BITS-1:0]            c,
	input  logic [PIXEL_BITS-1:0]            d,
	input  logic [PIXEL_BITS-1:0]            b,
	output logic                             v,
	output ffa_pkg::ctl_t                    ctl,
	output logic [NW-1:0]                    nc,
	output logic [NW-1:0]                    nb,
	output logic [ffa_pkg::MANT_WIDTH-1:0]   mc,
	output logic [ffa_pkg::MANT_WIDTH-1:0]   mb
);
	import ffa_pkg::*;

	logic signed [PIXEL_BITS:0] cd, bd;
	logic [PIXEL_BITS:0]        ncd, nbd;
	ctl_t                       ctl_c;
	logic                       v_s1;
	ctl_t                       ctl_s1;
	logic [PIXEL_BITS-1:0]      ac_s1, ab_s1;
	logic [NW-1:0]              nc_c, nb_c;

	assign cd  = $signed({1'b0, c}) - $signed({1'b0, d});
	assign bd  = $signed({1'b0, b}) - $signed({1'b0, d});
	assign ncd = -cd;
	assign nbd = -bd;

	always_comb begin
		ctl_c.ordinary = 1'b0;
		if (cd == '0 && bd == '0) begin
			ctl_c.status = STAT_BOTH;
		end else if (cd == '0) begin
			ctl_c.status = STAT_HIGH;
		end else if (bd == '0) begin
			ctl_c.status = STAT_LOW;
		end else if (cd[PIXEL_BITS] != bd[PIXEL_BITS]) begin
			ctl_c.status = STAT_NEG;
		end else begin
			ctl_c.status   = STAT_OK;
			ctl_c.ordinary = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl_c;
			ac_s1  <= cd[PIXEL_BITS] ? ncd[PIXEL_BITS-1:0] : cd[PIXEL_BITS-1:0];
			ab_s1  <= bd[PIXEL_BITS] ? nbd[PIXEL_BITS-1:0] : bd[PIXEL_BITS-1:0];
		end
	end

	// top set bit
	always_comb begin
		nc_c = '0;
		nb_c = '0;
		for (int i = 0; i < PIXEL_BITS; i++) begin
			if (ac_s1[i]) nc_c = NW'(i);
			if (ab_s1[i]) nb_c = NW'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= 1'b0;
		end else if (en) begin
			v <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl <= ctl_s1;
			nc  <= nc_c;
			nb  <= nb_c;
			mc  <= MANT_WIDTH'(ac_s1) << (5'd31 - 5'(nc_c));
			mb  <= MANT_WIDTH'(ab_s1) << (5'd31 - 5'(nb_c));
		end
	end

endmodule

// ----- sv/ffa_sq_stage.sv -----
// ----------------------------------------------------------------------------
// ffa_sq_stage
// one squaring step of the log2 fraction for both operands
// ----------------------------------------------------------------------------
module ffa_sq_stage #(
	parameter int NW = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             v_i,
	input  ffa_pkg::ctl_t                    ctl_i,
	input  logic [NW-1:0]                    nc_i,
	input  logic [NW-1:0]                    nb_i,
	input  logic [ffa_pkg::MANT_WIDTH-1:0]   mc_i,
	input  logic [ffa_pkg::MANT_WIDTH-1:0]   mb_i,
	input  logic [ffa_pkg::LOG_FRAC-1:0]     fc_i,
	input  logic [ffa_pkg::LOG_FRAC-1:0]     fb_i,
	output logic                             v_o,
	output ffa_pkg::ctl_t                    ctl_o,
	output logic [NW-1:0]                    nc_o,
	output logic [NW-1:0]                    nb_o,
	output logic [ffa_pkg::MANT_WIDTH-1:0]   mc_o,
	output logic [ffa_pkg::MANT_WIDTH-1:0]   mb_o,
	output logic [ffa_pkg::LOG_FRAC-1:0]     fc_o,
	output logic [ffa_pkg::LOG_FRAC-1:0]     fb_o
);
	import ffa_pkg::*;

	logic [2*MANT_WIDTH-1:0] sqc, sqb;
	logic [MANT_WIDTH:0]     tc, tb;

	assign sqc = 64'(mc_i) * 64'(mc_i);
	assign sqb = 64'(mb_i) * 64'(mb_i);
	assign tc  = sqc[2*MANT_WIDTH-1:MANT_WIDTH-1];
	assign tb  = sqb[2*MANT_WIDTH-1:MANT_WIDTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else if (en) begin
			v_o <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_o <= ctl_i;
			nc_o  <= nc_i;
			nb_o  <= nb_i;
			mc_o  <= tc[MANT_WIDTH] ? tc[MANT_WIDTH:1] : tc[MANT_WIDTH-1:0];
			mb_o  <= tb[MANT_WIDTH] ? tb[MANT_WIDTH:1] : tb[MANT_WIDTH-1:0];
			fc_o  <= {fc_i[LOG_FRAC-2:0], tc[MANT_WIDTH]};
			fb_o  <= {fb_i[LOG_FRAC-2:0], tb[MANT_WIDTH]};
		end
	end

endmodule

// ----- sv/ffa_scale.sv -----
// ----------------------------------------------------------------------------
// ffa_scale
// log difference, scaling by ln 2, rounding and clamping (four stages)
// ----------------------------------------------------------------------------
module ffa_scale #(
	parameter int FRAC_BITS = 16,
	parameter int NW        = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                v_i,
	input  ffa_pkg::ctl_t                       ctl_i,
	input  logic [NW-1:0]                       nc_i,
	input  logic [NW-1:0]                       nb_i,
	input  logic [ffa_pkg::LOG_FRAC-1:0]        fc_i,
	input  logic [ffa_pkg::LOG_FRAC-1:0]        fb_i,
	output logic                                out_valid,
	output logic signed [ffa_pkg::ATT_WIDTH-1:0] attenuation,
	output logic [ffa_pkg::STAT_WIDTH-1:0]      status
);
	import ffa_pkg::*;

	localparam int MW  = NW + LOG_FRAC;
	localparam int HW  = MW - LO_SPLIT;
	localparam int PRW = MW + LN2_WIDTH;
	localparam int RW  = PRW + 1;
	localparam int SH  = LOG_FRAC + 28 - FRAC_BITS;
	localparam int AW  = FRAC_BITS + 5;

	logic signed [MW:0]           diff;
	logic [MW:0]                  ndiff;
	logic                         v_s1, v_s2, v_s3;
	ctl_t                         ctl_s1, ctl_s2, ctl_s3;
	logic                         neg_s1, neg_s2, neg_s3;
	logic [MW-1:0]                mag_s1;
	logic [LO_SPLIT+LN2_WIDTH-1:0] lo_s2;
	logic [HW+LN2_WIDTH-1:0]      hi_s2;
	logic [PRW-1:0]               prod_s3;
	logic [RW-1:0]                rnd, r, lim;
	logic signed [AW-1:0]         att_c;
	logic signed [AW+ATT_WIDTH-1:0] att_ext;
	logic [STAT_WIDTH-1:0]        stat_c;

	assign diff  = $signed({1'b0, nb_i, fb_i}) - $signed({1'b0, nc_i, fc_i});
	assign ndiff = -diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= v_i;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1  <= ctl_i;
			neg_s1  <= diff[MW];
			mag_s1  <= diff[MW] ? ndiff[MW-1:0] : diff[MW-1:0];
			ctl_s2  <= ctl_s1;
			neg_s2  <= neg_s1;
			lo_s2   <= (LO_SPLIT+LN2_WIDTH)'(mag_s1[LO_SPLIT-1:0]) *
				(LO_SPLIT+LN2_WIDTH)'(LN2_Q28);
			hi_s2   <= (HW+LN2_WIDTH)'(mag_s1[MW-1:LO_SPLIT]) * (HW+LN2_WIDTH)'(LN2_Q28);
			ctl_s3  <= ctl_s2;
			neg_s3  <= neg_s2;
			prod_s3 <= (PRW'(hi_s2) << LO_SPLIT) + PRW'(lo_s2);
		end
	end

	assign rnd = RW'(prod_s3) + (RW'(1) << (SH - 1));
	assign r   = rnd >> SH;
	assign lim = RW'(12) << FRAC_BITS;

	always_comb begin
		att_c  = '0;
		stat_c = ctl_s3.status;
		if (ctl_s3.ordinary) begin
			if (r > lim) begin
				att_c  = neg_s3 ? -$signed(AW'(lim)) : $signed(AW'(lim));
				stat_c = neg_s3 ? STAT_LOW : STAT_HIGH;
			end else begin
				att_c = neg_s3 ? -$signed({1'b0, r[AW-2:0]}) : $signed({1'b0, r[AW-2:0]});
			end
		end else if (ctl_s3.status == STAT_HIGH) begin
			att_c = $signed(AW'(lim));
		end else if (ctl_s3.status == STAT_LOW) begin
			att_c = -$signed(AW'(lim));
		end
	end

	assign att_ext = {{ATT_WIDTH{att_c[AW-1]}}, att_c};

	always_ff @(posedge clk) begin
		if (en) begin
			attenuation <= att_ext[ATT_WIDTH-1:0];
			status      <= stat_c;
		end
	end

endmodule

// ----- sv/flat_field_attenuation.sv -----
// ----------------------------------------------------------------------------
// flat_field_attenuation
// per-pixel attenuation -ln((current-dark)/(bright-dark)) in signed fixed point
// ----------------------------------------------------------------------------
// channel  signals                                        direction
// in       in_valid/in_ready, current/dark/bright_count   into block
// out      out_valid/out_ready, attenuation, status        out of block
//
// one pixel per clock unless the output stalls; stages: 2 prep, 30 log squaring, 4 scale
// each log squaring stage holds two 32x32 multipliers, one per operand
// the whole pipeline advances when the output register is empty or taken
// arst_n clears only the valid bits
// ----------------------------------------------------------------------------
module flat_field_attenuation #(
	parameter int FRAC_BITS  = ffa_pkg::DEF_FRAC_BITS,
	parameter int PIXEL_BITS = ffa_pkg::DEF_PIXEL_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [ffa_pkg::COUNT_WIDTH-1:0]      current_count,
	input  logic [ffa_pkg::COUNT_WIDTH-1:0]      dark_count,
	input  logic [ffa_pkg::COUNT_WIDTH-1:0]      bright_count,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [ffa_pkg::ATT_WIDTH-1:0] attenuation,
	output logic [ffa_pkg::STAT_WIDTH-1:0]       status
);
	import ffa_pkg::*;

	localparam int NW = $clog2(PIXEL_BITS);

	logic                  en;
	logic                  v   [LOG_FRAC+1];
	ctl_t                  ctl [LOG_FRAC+1];
	logic [NW-1:0]         nc  [LOG_FRAC+1];
	logic [NW-1:0]         nb  [LOG_FRAC+1];
	logic [MANT_WIDTH-1:0] mc  [LOG_FRAC+1];
	logic [MANT_WIDTH-1:0] mb  [LOG_FRAC+1];
	logic [LOG_FRAC-1:0]   fc  [LOG_FRAC+1];
	logic [LOG_FRAC-1:0]   fb  [LOG_FRAC+1];

	assign en       = ~out_valid | out_ready;
	assign in_ready = en;
	assign fc[0]    = '0;
	assign fb[0]    = '0;

	ffa_prep #(.PIXEL_BITS(PIXEL_BITS), .NW(NW)) u_prep (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.c(current_count[PIXEL_BITS-1:0]), .d(dark_count[PIXEL_BITS-1:0]),
		.b(bright_count[PIXEL_BITS-1:0]),
		.v(v[0]), .ctl(ctl[0]), .nc(nc[0]), .nb(nb[0]), .mc(mc[0]), .mb(mb[0])
	);

	for (genvar g = 0; g < LOG_FRAC; g++) begin : g_sq
		ffa_sq_stage #(.NW(NW)) u_sq (
			.clk(clk), .arst_n(arst_n), .en(en),
			.v_i(v[g]), .ctl_i(ctl[g]), .nc_i(nc[g]), .nb_i(nb[g]),
			.mc_i(mc[g]), .mb_i(mb[g]), .fc_i(fc[g]), .fb_i(fb[g]),
			.v_o(v[g+1]), .ctl_o(ctl[g+1]), .nc_o(nc[g+1]), .nb_o(nb[g+1]),
			.mc_o(mc[g+1]), .mb_o(mb[g+1]), .fc_o(fc[g+1]), .fb_o(fb[g+1])
		);
	end

	ffa_scale #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_scale (
		.clk(clk), .arst_n(arst_n), .en(en),
		.v_i(v[LOG_FRAC]), .ctl_i(ctl[LOG_FRAC]),
		.nc_i(nc[LOG_FRAC]), .nb_i(nb[LOG_FRAC]),
		.fc_i(fc[LOG_FRAC]), .fb_i(fb[LOG_FRAC]),
		.out_valid(out_valid), .attenuation(attenuation), .status(status)
	);

endmodule

// ----- test/flat_field_attenuation_checker.sv -----
// ----------------------------------------------------------------------------
// flat_field_attenuation_checker
// watches both channels of the attenuation block, predicts -ln(cd/bd) and
// the status code for each pixel transfer and compares results in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flat_field_attenuation_checker
	import ffa_pkg::*;
#(
	parameter int FRAC_BITS  = DEF_FRAC_BITS,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [COUNT_WIDTH-1:0]        current_count,
	input  logic [COUNT_WIDTH-1:0]        dark_count,
	input  logic [COUNT_WIDTH-1:0]        bright_count,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic signed [ATT_WIDTH-1:0]   attenuation,
	input  logic [STAT_WIDTH-1:0]         status,
	output int                            errors,
	output int                            pending
);

	typedef struct packed {
		logic [ATT_WIDTH-1:0]  att;
		logic [STAT_WIDTH-1:0] stat;
	} pixel_result_t;

	pixel_result_t expected_pixels[$];

	function automatic longint unsigned log2_q30(input longint unsigned x);
		longint unsigned n;
		longint unsigned m;
		longint unsigned frac;
		n = 0;
		frac = 0;
		while (n < 31 && (x >> (n + 1)) != 0)
			n++;
		m = x << (31 - n);
		for (int i = 0; i < LOG_FRAC; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= (64'd1 << 32)) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		return (n << LOG_FRAC) | frac;
	endfunction

	function automatic pixel_result_t attenuation_of(input logic [COUNT_WIDTH-1:0] c,
			input logic [COUNT_WIDTH-1:0] d, input logic [COUNT_WIDTH-1:0] b);
		longint pmask;
		longint limit;
		longint cd;
		longint bd;
		longint att;
		longint diff;
		longint unsigned mag;
		longint unsigned r;
		logic [STAT_WIDTH-1:0] st;
		pixel_result_t res;
		pmask = (64'd1 << PIXEL_BITS) - 1;
		limit = 64'sd12 << FRAC_BITS;
		cd = (c & pmask) - (d & pmask);
		bd = (b & pmask) - (d & pmask);
		att = 0;
		st = STAT_OK;
		if (cd == 0 && bd == 0) begin
			st = STAT_BOTH;
		end else if (cd == 0) begin
			att = limit;
			st = STAT_HIGH;
		end else if (bd == 0) begin
			att = -limit;
			st = STAT_LOW;
		end else if ((cd < 0) != (bd < 0)) begin
			st = STAT_NEG;
		end else begin
			diff = longint'(log2_q30(bd < 0 ? -bd : bd)) - longint'(log2_q30(cd < 0 ? -cd : cd));
			mag = diff < 0 ? -diff : diff;
			r = (mag * LN2_Q28 + (64'd1 << (LOG_FRAC + 27 - FRAC_BITS)))
				>> (LOG_FRAC + 28 - FRAC_BITS);
			att = diff < 0 ? -longint'(r) : longint'(r);
			if (att > limit) begin
				att = limit;
				st = STAT_HIGH;
			end else if (att < -limit) begin
				att = -limit;
				st = STAT_LOW;
			end
		end
		res.att = att[ATT_WIDTH-1:0];
		res.stat = st;
		return res;
	endfunction

	assign pending = expected_pixels.size();

	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_pixels.push_back(attenuation_of(current_count, dark_count, bright_count));
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					errors <= errors + 1;
					$display("%0t: unexpected transfer att %0d status %0d", $time, attenuation, status);
				end else begin
					want = expected_pixels.pop_front();
					if (want.att !== attenuation || want.stat !== status) begin
						errors <= errors + 1;
						$display("%0t: mismatch expected att %0d status %0d actual att %0d status %0d",
							$time, $signed(want.att), want.stat, attenuation, status);
					end
				end
			end
		end
	end

	initial errors = 0;

endmodule

// ----- test/flat_field_attenuation_tb.sv -----
// ----------------------------------------------------------------------------
// flat_field_attenuation_tb
// drives pixels with directed corner cases and random counts under varying
// backpressure; the checker predicts and compares each result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flat_field_attenuation_tb;
	import ffa_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 50;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [COUNT_WIDTH-1:0] current_count;
	logic [COUNT_WIDTH-1:0] dark_count;
	logic [COUNT_WIDTH-1:0] bright_count;
	logic out_valid;
	logic out_ready;
	logic signed [ATT_WIDTH-1:0] attenuation;
	logic [STAT_WIDTH-1:0] status;
	int errors;
	int pending;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_recv;
	int idle_cycles;

	flat_field_attenuation dut (.*);

	flat_field_attenuation_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_recv)
				out_ready <= 0;
			else
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_pixel(input logic [15:0] c, input logic [15:0] d, input logic [15:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		current_count <= c;
		dark_count <= d;
		bright_count <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_random;
		logic [15:0] d;
		d = 16'($urandom);
		case ($urandom_range(5))
			0: send_pixel(16'($urandom), 16'($urandom), 16'($urandom));
			1: send_pixel(d + 16'($urandom_range(4000)), d, d + 16'($urandom_range(4000)));
			2: send_pixel(d - 16'($urandom_range(30)), d, d - 16'($urandom_range(30)));
			3: send_pixel(d, d, $urandom_range(1) ? d : 16'($urandom));
			4: send_pixel($urandom_range(1) ? d : 16'($urandom), d, d);
			default: send_pixel(16'($urandom_range(3)), 16'($urandom_range(3)),
				16'($urandom_range(3)));
		endcase
	endtask

	task automatic wait_drained;
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		current_count = 0;
		dark_count = 0;
		bright_count = 0;
		hold_recv = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_pixel(0, 0, 0);
		send_pixel(100, 100, 100);
		send_pixel(100, 100, 500);
		send_pixel(500, 100, 100);
		send_pixel(50, 100, 100);
		send_pixel(50, 100, 500);
		send_pixel(500, 100, 50);
		send_pixel(16'hffff, 0, 16'hffff);
		send_pixel(1, 0, 16'hffff);
		send_pixel(16'hffff, 0, 1);
		send_pixel(0, 16'hffff, 0);
		send_pixel(16'hfffe, 16'hffff, 0);
		send_pixel(0, 16'hffff, 16'hfffe);
		send_pixel(2, 0, 1);
		send_pixel(3, 1, 5);
		send_pixel(16'h8000, 16'h7fff, 16'hffff);
		send_pixel(16'h5555, 16'haaaa, 16'h0000);
		send_pixel(16'haaaa, 16'h5555, 16'hffff);

		send_idle_pct = 31;
		recv_idle_pct = 86;
		repeat (550) send_random();

		hold_recv = 1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_recv = 0;
			end
			repeat (60) send_random();
		join
		wait_drained();

		send_idle_pct = 86;
		recv_idle_pct = 31;
		repeat (500) send_random();
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (550) send_random();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
